### hdl/vehist_pkg.sv
package vehist_pkg;

    // Fixed field widths of the request and response channels
    localparam int SLOT_W      = 7;
    localparam int VALUE_W     = 32;
    localparam int HIT_W       = 7;
    localparam int COUNT_OUT_W = 32;
    localparam int NE_W        = 7;

    // Operation codes
    localparam logic [1:0] OP_WRITE_EDGE = 2'd0;
    localparam logic [1:0] OP_COUNT      = 2'd1;
    localparam logic [1:0] OP_READ       = 2'd2;
    localparam logic [1:0] OP_CLEAR      = 2'd3;

    // Edge count register value after reset
    localparam logic [NE_W-1:0] NUM_EDGES_RESET = 7'd64;

    // Top level sequencer
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_CTR_UPD,
        ST_CTR_GET,
        ST_RESP
    } ctrl_state_t;

    // Search engine sequencer
    typedef enum logic [1:0] {
        SRCH_IDLE,
        SRCH_RUN,
        SRCH_DONE
    } srch_state_t;

    // Search launch
    typedef struct packed {
        logic                      start;
        logic signed [VALUE_W-1:0] sample;
    } srch_req_t;

    // Edge table write
    typedef struct packed {
        logic                      we;
        logic [SLOT_W-1:0]         slot;
        logic signed [VALUE_W-1:0] value;
    } edge_wr_t;

endpackage

### hdl/vehist_search.sv
module vehist_search #(
    parameter int MAX_EDGES = 64,
    localparam int IW = $clog2(MAX_EDGES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vehist_pkg::srch_req_t req,
    input  vehist_pkg::edge_wr_t  edge_wr,
    input  logic [IW-1:0]        n,
    output logic                 done,
    output logic [IW-1:0]        idx
);

    localparam int EAW = $clog2(MAX_EDGES);
    localparam int SXW = (vehist_pkg::SLOT_W > IW) ? vehist_pkg::SLOT_W : IW;

    // Edge table: one write port, one registered read port
    logic signed [vehist_pkg::VALUE_W-1:0] edge_mem [0:MAX_EDGES-1];
    logic signed [vehist_pkg::VALUE_W-1:0] edge_rd_reg;

    vehist_pkg::srch_state_t state_reg, state_next;

    logic [IW-1:0] first_reg, first_next;
    logic [IW-1:0] len_reg, len_next;
    logic [IW-1:0] probe_reg, probe_next;
    logic signed [vehist_pkg::VALUE_W-1:0] sample_reg, sample_next;

    logic          rd_en;
    logic [IW-1:0] rd_ptr;
    logic [SXW-1:0] slot_ext;
    logic [IW-1:0] half;
    logic          go_right;
    logic [IW-1:0] first_upd;
    logic [IW-1:0] len_upd;

    // One search step: the probed edge arrived this cycle
    always_comb
    begin
        half      = len_reg >> 1;
        go_right  = (edge_rd_reg <= sample_reg);
        first_upd = go_right ? (probe_reg + IW'(1)) : first_reg;
        len_upd   = go_right ? (len_reg - half - IW'(1)) : half;
        slot_ext  = SXW'(edge_wr.slot);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vehist_pkg::SRCH_IDLE:
            begin
                if (req.start)
                begin
                    state_next = (n == '0) ? vehist_pkg::SRCH_DONE : vehist_pkg::SRCH_RUN;
                end
            end
            vehist_pkg::SRCH_RUN:
            begin
                state_next = (len_upd == '0) ? vehist_pkg::SRCH_DONE : vehist_pkg::SRCH_RUN;
            end
            vehist_pkg::SRCH_DONE:
            begin
                state_next = vehist_pkg::SRCH_IDLE;
            end
            default:
            begin
                state_next = vehist_pkg::SRCH_IDLE;
            end
        endcase
    end

    // Outputs and datapath controls
    always_comb
    begin
        done        = 1'b0;
        rd_en       = 1'b0;
        rd_ptr      = probe_reg;
        first_next  = first_reg;
        len_next    = len_reg;
        probe_next  = probe_reg;
        sample_next = sample_reg;
        case (state_reg)
            vehist_pkg::SRCH_IDLE:
            begin
                if (req.start)
                begin
                    first_next  = '0;
                    len_next    = n;
                    sample_next = req.sample;
                    rd_ptr      = n >> 1;
                    probe_next  = n >> 1;
                    rd_en       = (n != '0);
                end
            end
            vehist_pkg::SRCH_RUN:
            begin
                first_next = first_upd;
                len_next   = len_upd;
                rd_ptr     = first_upd + (len_upd >> 1);
                probe_next = rd_ptr;
                rd_en      = (len_upd != '0);
            end
            vehist_pkg::SRCH_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    assign idx = first_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vehist_pkg::SRCH_IDLE;
            first_reg <= '0;
            len_reg   <= '0;
            probe_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            len_reg   <= len_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    // Edge memory
    always_ff @(posedge clk)
    begin
        if (edge_wr.we)
        begin
            edge_mem[slot_ext[EAW-1:0]] <= edge_wr.value;
        end
        if (rd_en)
        begin
            edge_rd_reg <= edge_mem[rd_ptr[EAW-1:0]];
        end
    end

endmodule

### hdl/variable_edge_histogram_unit.sv
// Histogram with programmable, non-uniform bin edges.
// Request channel (in_valid/in_ready): operation, slot, sample_value.
//   write edge stores sample_value at edge slot; count places sample_value
//   by binary upper-bound search and bumps that counter (saturating);
//   read returns counter slot; clear zeroes all counters.
// Response channel (out_valid/out_ready): bin_hit, count_value, error.
//   Exactly one response per request, in request order.
// cfg_we/cfg_wdata set the number of edges in use; write only while idle.
// One request is in flight at a time. After acceptance, write edge and a
// rejected read go straight to the response state; a read first fetches its
// counter; count runs the search (one search probe per cycle through the
// edge memory read port), then a counter read and its write-back; clear
// sweeps the counter memory one entry a cycle. The next request can be
// taken in the cycle after the response of the previous one is loaded.
// After reset the same sweep runs before the first request is taken; the
// edge count resets to 64, edges are undefined.
// A response waits in the output register while out_ready is low; the
// next request is accepted meanwhile and holds only at its own response.
module variable_edge_histogram_unit #(
    parameter int MAX_EDGES   = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            operation,
    input  logic [vehist_pkg::SLOT_W-1:0]         slot,
    input  logic signed [vehist_pkg::VALUE_W-1:0] sample_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [vehist_pkg::HIT_W-1:0]          bin_hit,
    output logic [vehist_pkg::COUNT_OUT_W-1:0]    count_value,
    output logic                                  error,
    input  logic                                  cfg_we,
    input  logic [vehist_pkg::NE_W-1:0]           cfg_wdata
);

    localparam int IW   = $clog2(MAX_EDGES + 1);
    localparam int CMPW = (vehist_pkg::SLOT_W > IW) ? vehist_pkg::SLOT_W : IW;
    localparam int HXW  = (vehist_pkg::HIT_W > IW) ? vehist_pkg::HIT_W : IW;
    localparam int CXW  = (vehist_pkg::COUNT_OUT_W > COUNT_WIDTH) ?
                          vehist_pkg::COUNT_OUT_W : COUNT_WIDTH;
    localparam logic [CMPW-1:0]        MAX_CMP   = CMPW'(MAX_EDGES);
    localparam logic [IW-1:0]          LAST_CTR  = IW'(MAX_EDGES);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    vehist_pkg::ctrl_state_t state_reg, state_next;

    logic [vehist_pkg::NE_W-1:0] num_edges_reg;
    logic [IW-1:0]               clr_idx_reg;
    logic                        clr_resp_reg;
    logic                        out_valid_reg;

    logic [IW-1:0]          res_hit_reg;
    logic [COUNT_WIDTH-1:0] res_cnt_reg;
    logic                   res_err_reg;

    logic [vehist_pkg::HIT_W-1:0]       bin_hit_reg;
    logic [vehist_pkg::COUNT_OUT_W-1:0] count_value_reg;
    logic                               error_reg;

    // Counter memory
    logic [COUNT_WIDTH-1:0] cnt_mem [0:MAX_EDGES];
    logic [COUNT_WIDTH-1:0] ctr_rd_reg;
    logic                   ctr_rd_en;
    logic [IW-1:0]          ctr_rd_addr;
    logic                   ctr_we;
    logic [IW-1:0]          ctr_wr_addr;
    logic [COUNT_WIDTH-1:0] ctr_wdata;
    logic [COUNT_WIDTH-1:0] sat_inc;

    vehist_pkg::srch_req_t srch_req;
    vehist_pkg::edge_wr_t  edge_wr;
    logic                  srch_done;
    logic [IW-1:0]         srch_idx;

    logic [CMPW-1:0] slot_ext;
    logic [CMPW-1:0] num_ext;
    logic [CMPW-1:0] n_ext;
    logic [IW-1:0]   n_eff;
    logic            wr_ok;
    logic            rd_ok;
    logic            in_acc;
    logic            can_load;
    logic            out_load;
    logic [HXW-1:0]  hit_ext;
    logic [CXW-1:0]  cnt_ext;

    // Range checks and effective edge count
    always_comb
    begin
        slot_ext = CMPW'(slot);
        num_ext  = CMPW'(num_edges_reg);
        n_eff    = (num_ext > MAX_CMP) ? MAX_CMP[IW-1:0] : num_ext[IW-1:0];
        n_ext    = CMPW'(n_eff);
        wr_ok    = (slot_ext < MAX_CMP);
        rd_ok    = (slot_ext <= n_ext);
        sat_inc  = (ctr_rd_reg == COUNT_MAX) ? ctr_rd_reg : (ctr_rd_reg + COUNT_WIDTH'(1));
        can_load = !out_valid_reg || out_ready;
        in_acc   = in_valid && (state_reg == vehist_pkg::ST_IDLE);
        hit_ext  = HXW'(res_hit_reg);
        cnt_ext  = CXW'(res_cnt_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vehist_pkg::ST_CLEAR:
            begin
                if (clr_idx_reg == LAST_CTR)
                begin
                    state_next = clr_resp_reg ? vehist_pkg::ST_RESP : vehist_pkg::ST_IDLE;
                end
            end
            vehist_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (operation)
                        vehist_pkg::OP_WRITE_EDGE: state_next = vehist_pkg::ST_RESP;
                        vehist_pkg::OP_COUNT:      state_next = vehist_pkg::ST_SEARCH;
                        vehist_pkg::OP_READ:
                            state_next = rd_ok ? vehist_pkg::ST_CTR_GET : vehist_pkg::ST_RESP;
                        vehist_pkg::OP_CLEAR:      state_next = vehist_pkg::ST_CLEAR;
                        default:                   state_next = vehist_pkg::ST_RESP;
                    endcase
                end
            end
            vehist_pkg::ST_SEARCH:
            begin
                if (srch_done)
                begin
                    state_next = vehist_pkg::ST_CTR_UPD;
                end
            end
            vehist_pkg::ST_CTR_UPD:
            begin
                state_next = vehist_pkg::ST_RESP;
            end
            vehist_pkg::ST_CTR_GET:
            begin
                state_next = vehist_pkg::ST_RESP;
            end
            vehist_pkg::ST_RESP:
            begin
                if (can_load)
                begin
                    state_next = vehist_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vehist_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_ready        = 1'b0;
        out_load        = 1'b0;
        ctr_rd_en       = 1'b0;
        ctr_rd_addr     = slot_ext[IW-1:0];
        ctr_we          = 1'b0;
        ctr_wr_addr     = res_hit_reg;
        ctr_wdata       = sat_inc;
        srch_req.start  = 1'b0;
        srch_req.sample = sample_value;
        edge_wr.we      = 1'b0;
        edge_wr.slot    = slot;
        edge_wr.value   = sample_value;
        case (state_reg)
            vehist_pkg::ST_CLEAR:
            begin
                ctr_we      = 1'b1;
                ctr_wr_addr = clr_idx_reg;
                ctr_wdata   = '0;
            end
            vehist_pkg::ST_IDLE:
            begin
                in_ready       = 1'b1;
                edge_wr.we     = in_acc && (operation == vehist_pkg::OP_WRITE_EDGE) && wr_ok;
                srch_req.start = in_acc && (operation == vehist_pkg::OP_COUNT);
                ctr_rd_en      = in_acc && (operation == vehist_pkg::OP_READ) && rd_ok;
            end
            vehist_pkg::ST_SEARCH:
            begin
                ctr_rd_en   = srch_done;
                ctr_rd_addr = srch_idx;
            end
            vehist_pkg::ST_CTR_UPD:
            begin
                ctr_we = 1'b1;
            end
            vehist_pkg::ST_RESP:
            begin
                out_load = can_load;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    vehist_search #(
        .MAX_EDGES(MAX_EDGES)
    ) u_search (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (srch_req),
        .edge_wr(edge_wr),
        .n      (n_eff),
        .done   (srch_done),
        .idx    (srch_idx)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vehist_pkg::ST_CLEAR;
            num_edges_reg <= vehist_pkg::NUM_EDGES_RESET;
            clr_idx_reg   <= '0;
            clr_resp_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                num_edges_reg <= cfg_wdata;
            end
            if (in_acc && (operation == vehist_pkg::OP_CLEAR))
            begin
                clr_idx_reg  <= '0;
                clr_resp_reg <= 1'b1;
            end
            else if ((state_reg == vehist_pkg::ST_CLEAR) && (clr_idx_reg != LAST_CTR))
            begin
                clr_idx_reg <= clr_idx_reg + IW'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result of the request in flight
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            res_err_reg <= ((operation == vehist_pkg::OP_WRITE_EDGE) && !wr_ok) ||
                           ((operation == vehist_pkg::OP_READ) && !rd_ok);
            res_hit_reg <= ((operation == vehist_pkg::OP_READ) && rd_ok) ?
                           slot_ext[IW-1:0] : '0;
            res_cnt_reg <= '0;
        end
        else if ((state_reg == vehist_pkg::ST_SEARCH) && srch_done)
        begin
            res_hit_reg <= srch_idx;
        end
        else if (state_reg == vehist_pkg::ST_CTR_UPD)
        begin
            res_cnt_reg <= sat_inc;
        end
        else if (state_reg == vehist_pkg::ST_CTR_GET)
        begin
            res_cnt_reg <= ctr_rd_reg;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            bin_hit_reg     <= hit_ext[vehist_pkg::HIT_W-1:0];
            count_value_reg <= cnt_ext[vehist_pkg::COUNT_OUT_W-1:0];
            error_reg       <= res_err_reg;
        end
    end

    // Counter memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctr_we)
        begin
            cnt_mem[ctr_wr_addr] <= ctr_wdata;
        end
        if (ctr_rd_en)
        begin
            ctr_rd_reg <= cnt_mem[ctr_rd_addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign bin_hit     = bin_hit_reg;
    assign count_value = count_value_reg;
    assign error       = error_reg;

    // A response appears only from the response state
    a_load_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == vehist_pkg::ST_RESP))
        else $error("response raised outside the response state");

    // A counted bin never reads back as zero
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vehist_pkg::ST_CTR_UPD) |=> (res_cnt_reg != '0))
        else $error("count result is zero after increment");

    // Search completes only while the sequencer waits for it
    a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        srch_done |-> (state_reg == vehist_pkg::ST_SEARCH))
        else $error("search done outside the search state");

    // Search index stays within the edges in use
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        srch_done |-> (srch_idx <= n_eff))
        else $error("search index beyond edge count");

endmodule
